FILE: sv/echo_distance_color_ramp_defines.svh
// Assertion macros shared by the echo distance color ramp RTL.
`ifndef ECHO_DISTANCE_COLOR_RAMP_DEFINES_SVH
`define ECHO_DISTANCE_COLOR_RAMP_DEFINES_SVH

`ifndef SYNTHESIS

`define ECR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ECR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ECR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ECR_ASSERT(label, prop, msg)

`define ECR_ASSERT_IMP(label, ante, cons, msg)

`define ECR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: sv/ecr_pkg.sv
// Types and constants shared by the echo distance color ramp modules.
package ecr_pkg;

    localparam int ECHO_W = 20;
    localparam int DIST_W = 11;
    localparam int RGB_W  = 8;
    localparam int PROD_W = 25;
    localparam int QUO_W  = DIST_W;
    localparam int DVD_W  = 19;
    localparam int DSR_W  = DIST_W + QUO_W - 1;
    localparam int CNT_W  = 4;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int OUTLIER_MM  = 2000;
    localparam int DIST_DIV    = 100;
    localparam int SOUND_MUL   = 17;
    localparam int OUTLIER_PROD = (OUTLIER_MM + 1) * DIST_DIV;
    localparam logic [RGB_W-1:0] FULL_SCALE = 8'd255;

    localparam logic [DIST_W-1:0] NEAR_RST = 11'd100;
    localparam logic [DIST_W-1:0] MID_RST  = 11'd300;
    localparam logic [DIST_W-1:0] FAR_RST  = 11'd500;

    typedef enum logic [1:0] {
        REG_NEAR = 2'd0,
        REG_MID  = 2'd1,
        REG_FAR  = 2'd2,
        REG_NONE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0] near_mm;
        logic [DIST_W-1:0] mid_mm;
        logic [DIST_W-1:0] far_mm;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic              long_q;
        logic [DVD_W-1:0]  dividend;
        logic [DIST_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIST  = 6'b000010,
        S_CLAMP = 6'b000100,
        S_SEG   = 6'b001000,
        S_RAMP  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

FILE: sv/ecr_regs.sv
// APB configuration registers for the near, mid and far distance limits.
module ecr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ecr_pkg::DATA_W-1:0]  pwdata,
    output logic [ecr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ecr_pkg::cfg_t               cfg
);
    import ecr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_mm <= NEAR_RST;
            cfg_reg.mid_mm  <= MID_RST;
            cfg_reg.far_mm  <= FAR_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_NEAR: cfg_reg.near_mm <= pwdata[DIST_W-1:0];
                REG_MID:  cfg_reg.mid_mm  <= pwdata[DIST_W-1:0];
                REG_FAR:  cfg_reg.far_mm  <= pwdata[DIST_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_NEAR: prdata = DATA_W'(cfg_reg.near_mm);
            REG_MID:  prdata = DATA_W'(cfg_reg.mid_mm);
            REG_FAR:  prdata = DATA_W'(cfg_reg.far_mm);
            default:  prdata = '0;
        endcase
    end

endmodule

FILE: sv/ecr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ecr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ecr_pkg::div_req_t   req,
    output ecr_pkg::div_rsp_t   rsp
);
    import ecr_pkg::*;

    logic [DVD_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [DSR_W:0]   diff;
    logic             ge;

    // The divisor sits in a shift register aligned to the current quotient bit.
    assign diff = {1'b0, {(DSR_W-DVD_W){1'b0}}, rem_reg} - {1'b0, dsr_reg};
    assign ge   = ~diff[DSR_W];

    assign rsp.busy = active_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= req.long_q ? CNT_W'(QUO_W - 1) : CNT_W'(RGB_W - 1);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            quo_reg <= '0;
            if (req.long_q)
                dsr_reg <= DSR_W'(req.divisor) << (QUO_W - 1);
            else
                dsr_reg <= DSR_W'(req.divisor) << (RGB_W - 1);
        end
        else if (active_reg)
        begin
            rem_reg <= ge ? diff[DVD_W-1:0] : rem_reg;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsr_reg <= dsr_reg >> 1;
        end
    end

endmodule

FILE: sv/echo_distance_color_ramp.sv
// Top level: echo time to clamped distance and a two-segment color gradient.
// One echo item yields one color item. The distance is a quotient of a shared
// bit-serial divider (floor(17*echo/100)), and the ramp value is a second
// quotient of the same divider; accept, clamp, segment select and output load
// are separate states. Outlier echoes skip the distance division, and zero or
// empty spans skip the ramp division, so these finish sooner. A new item is
// taken as soon as the previous one is in the output register, even if that
// result has not yet been taken. Registers near_mm, mid_mm and far_mm live at
// byte addresses 0, 4 and 8 of the APB port.
`include "echo_distance_color_ramp_defines.svh"

module echo_distance_color_ramp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ecr_pkg::ADDR_W-1:0]   paddr,
    input  logic [ecr_pkg::DATA_W-1:0]   pwdata,
    output logic [ecr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ecr_pkg::ECHO_W-1:0]   echo_us,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ecr_pkg::RGB_W-1:0]    red,
    output logic [ecr_pkg::RGB_W-1:0]    green,
    output logic [ecr_pkg::RGB_W-1:0]    blue,
    output logic [ecr_pkg::DIST_W-1:0]   range_mm
);
    import ecr_pkg::*;

    cfg_t              cfg;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    state_t            state_reg, state_next;

    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] last_range_reg;
    logic [RGB_W-1:0]  t_reg;
    logic              seg1_reg, seg2_reg;
    logic [RGB_W-1:0]  red_reg, green_reg, blue_reg;
    logic [DIST_W-1:0] range_reg;
    logic              out_valid_reg;

    logic [PROD_W-1:0] prod;
    logic              outlier;
    logic              accept;
    logic [DIST_W-1:0] clamped;
    logic              seg1, seg2;
    logic [DIST_W-1:0] lo, hi, span, off;
    logic [DVD_W-1:0]  num;
    logic              load_out;

    ecr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // 17*echo as a shift and add; the distance exceeds the outlier limit exactly
    // when this product reaches (limit+1)*100.
    assign prod    = PROD_W'({echo_us, 4'b0000}) + PROD_W'(echo_us);
    assign outlier = (prod >= PROD_W'(OUTLIER_PROD));
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        if (dist_reg < cfg.near_mm)
            clamped = cfg.near_mm;
        else if (dist_reg > cfg.far_mm)
            clamped = cfg.far_mm;
        else
            clamped = dist_reg;
    end

    assign seg1 = (cfg.near_mm <= dist_reg) && (dist_reg <= cfg.mid_mm);
    assign seg2 = (cfg.mid_mm <= dist_reg) && (dist_reg <= cfg.far_mm);
    assign lo   = seg1 ? cfg.near_mm : cfg.mid_mm;
    assign hi   = seg1 ? cfg.mid_mm : cfg.far_mm;
    assign span = hi - lo;
    assign off  = dist_reg - lo;
    assign num  = DVD_W'({off, 8'b0000_0000}) - DVD_W'(off);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.long_q   = (state_reg == S_IDLE);
        div_req.dividend = num;
        div_req.divisor  = span;
        if (state_reg == S_IDLE)
        begin
            div_req.start    = accept & ~outlier;
            div_req.dividend = prod[DVD_W-1:0];
            div_req.divisor  = DIST_W'(DIST_DIV);
        end
        else if (state_reg == S_SEG)
        begin
            div_req.start = (seg1 | seg2) && (span != '0);
        end
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = outlier ? S_CLAMP : S_DIST;
            end
            S_DIST:
            begin
                if (div_rsp.done)
                    state_next = S_CLAMP;
            end
            S_CLAMP: state_next = S_SEG;
            S_SEG:   state_next = div_req.start ? S_RAMP : S_DONE;
            S_RAMP:
            begin
                if (div_rsp.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            last_range_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLAMP)
                last_range_reg <= clamped;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && outlier)
            dist_reg <= last_range_reg;
        else if (state_reg == S_DIST && div_rsp.done)
            dist_reg <= div_rsp.quo;
        else if (state_reg == S_CLAMP)
            dist_reg <= clamped;

        if (state_reg == S_SEG)
        begin
            seg1_reg <= seg1;
            seg2_reg <= seg2 & ~seg1;
            t_reg    <= FULL_SCALE;
        end
        else if (state_reg == S_RAMP && div_rsp.done)
            t_reg <= div_rsp.quo[RGB_W-1:0];

        if (load_out)
        begin
            range_reg <= dist_reg;
            red_reg   <= seg1_reg ? (FULL_SCALE - t_reg) : '0;
            blue_reg  <= seg2_reg ? t_reg : '0;
            if (seg1_reg)
                green_reg <= t_reg;
            else if (seg2_reg)
                green_reg <= FULL_SCALE - t_reg;
            else
                green_reg <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign range_mm  = range_reg;

    `ECR_ASSERT_IMP(a_ready_div_idle, in_ready, !div_rsp.busy, "divider busy while taking an item")
    `ECR_ASSERT_IMP(a_done_state, div_rsp.done, (state_reg == S_DIST) || (state_reg == S_RAMP), "divider finished outside a divide step")
    `ECR_ASSERT_IMP(a_dist_limit, div_rsp.done && (state_reg == S_DIST), div_rsp.quo <= DIST_W'(OUTLIER_MM), "distance quotient above outlier limit")
    `ECR_ASSERT_NEXT(a_load_range, load_out, out_valid && (range_mm == last_range_reg), "result range differs from stored range")

endmodule
